// ===== rtl/core/x64uwd_pkg.sv =====
// Package for the x64 unwind code decoder: slot and result transfer types,
// operation codes and fixed constants. It depends on nothing else.
package x64uwd_pkg;

    typedef struct packed {
        logic [15:0] slot_word;
        logic        start_of_record;
        logic        last_slot;
    } slot_t;

    typedef struct packed {
        logic               record_kind;
        logic [4:0]         reg_id;
        logic signed [31:0] frame_offset;
        logic               is_xmm;
        logic [31:0]        frame_size;
        logic [31:0]        stack_depth;
        logic               truncated;
        logic               last_result;
    } result_t;

    localparam logic [3:0] OP_PUSH_NONVOL    = 4'd0;
    localparam logic [3:0] OP_ALLOC_LARGE    = 4'd1;
    localparam logic [3:0] OP_ALLOC_SMALL    = 4'd2;
    localparam logic [3:0] OP_SAVE_NONVOL    = 4'd4;
    localparam logic [3:0] OP_SAVE_NONVOL_FAR = 4'd5;
    localparam logic [3:0] OP_SAVE_XMM128    = 4'd8;
    localparam logic [3:0] OP_SAVE_XMM128_FAR = 4'd9;
    localparam logic [3:0] OP_PUSH_MACHFRAME = 4'd10;

    localparam logic KIND_SAVE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [31:0] DEPTH_RESET      = 32'd8;
    localparam logic [31:0] PUSH_BYTES       = 32'd8;
    localparam logic [31:0] MACHFRAME_CODE   = 32'd48;
    localparam logic [31:0] MACHFRAME_NOCODE = 32'd40;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

endpackage

// ===== rtl/core/x64_unwind_code_decoder.sv =====
// Top level of the x64 unwind code decoder: slot decode, running stack state
// and a four-entry result queue. It depends on x64uwd_pkg.
//
// The decoder takes one unwind code slot per cycle when not stalled and decodes
// it in the same cycle that it is transferred, updating the stack depth, frame
// size and operand state and writing its results into a four-entry result
// queue. A slot yields no result, one result, or two (a register save and the
// end-of-record summary), so slots with at most one result run at one per
// cycle when not stalled, and the sustained rate is bounded by the single
// result port, which delivers one result per cycle unless result_stall is
// high. Results are written into the queue at the edge that transfers the
// slot. Slot transfers stall while fewer than two queue entries are free.
module x64_unwind_code_decoder
    import x64uwd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    slot_valid,
    output logic    slot_stall,
    input  slot_t   slot,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic [31:0] stack_reg, stack_next;
    logic [31:0] alloc_reg, alloc_next;
    logic [3:0]  pop_reg, pop_next;
    logic [3:0]  preg_reg, preg_next;
    logic [1:0]  left_reg, left_next;
    logic [15:0] low_reg, low_next;

    result_t          fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic        slot_fire, result_fire;
    logic [31:0] stack_base, alloc_base;
    logic [3:0]  pop_base, preg_base, op, rg;
    logic [1:0]  left_base;
    logic        two;
    logic [31:0] val;
    logic        save, truncated;
    logic [4:0]  s_reg;
    logic [31:0] s_off;
    logic        s_xmm;
    result_t     save_rec, sum_rec;
    logic [1:0]  push_n;

    assign slot_fire   = slot_valid && !slot_stall;
    assign result_fire = result_valid && !result_stall;

    always_comb
    begin
        stack_base = slot.start_of_record ? DEPTH_RESET : stack_reg;
        alloc_base = slot.start_of_record ? 32'd0 : alloc_reg;
        pop_base   = slot.start_of_record ? 4'd0 : pop_reg;
        preg_base  = slot.start_of_record ? 4'd0 : preg_reg;
        left_base  = slot.start_of_record ? 2'd0 : left_reg;
        op = slot.slot_word[11:8];
        rg = slot.slot_word[15:12];
        two = (pop_base == OP_SAVE_NONVOL_FAR) || (pop_base == OP_SAVE_XMM128_FAR)
            || ((pop_base == OP_ALLOC_LARGE) && (preg_base != 4'd0));
        val = two ? {slot.slot_word, low_reg} : {16'd0, slot.slot_word};

        stack_next = stack_base;
        alloc_next = alloc_base;
        pop_next   = pop_base;
        preg_next  = preg_base;
        left_next  = left_base;
        low_next   = slot.start_of_record ? 16'd0 : low_reg;
        save  = 1'b0;
        s_reg = 5'd0;
        s_off = 32'd0;
        s_xmm = 1'b0;

        if (left_base == 2'd2)
        begin
            low_next  = slot.slot_word;
            left_next = 2'd1;
        end
        else if (left_base == 2'd1)
        begin
            left_next = 2'd0;
            case (pop_base)
                OP_ALLOC_LARGE:
                begin
                    alloc_next = alloc_base + (two ? val : {val[28:0], 3'd0});
                    stack_next = stack_base + (two ? val : {val[28:0], 3'd0});
                end
                OP_SAVE_NONVOL:
                begin
                    save  = 1'b1;
                    s_reg = {1'b0, preg_base};
                    s_off = {val[28:0], 3'd0};
                end
                OP_SAVE_NONVOL_FAR:
                begin
                    save  = 1'b1;
                    s_reg = {1'b0, preg_base};
                    s_off = val;
                end
                OP_SAVE_XMM128:
                begin
                    save  = 1'b1;
                    s_reg = {1'b1, preg_base};
                    s_off = {val[27:0], 4'd0};
                    s_xmm = 1'b1;
                end
                OP_SAVE_XMM128_FAR:
                begin
                    save  = 1'b1;
                    s_reg = {1'b1, preg_base};
                    s_off = val;
                    s_xmm = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            pop_next  = op;
            preg_next = rg;
            case (op)
                OP_PUSH_NONVOL:
                begin
                    save       = 1'b1;
                    s_reg      = {1'b0, rg};
                    s_off      = 32'd0 - stack_base - PUSH_BYTES;
                    stack_next = stack_base + PUSH_BYTES;
                end
                OP_ALLOC_LARGE:
                begin
                    left_next = (rg != 4'd0) ? 2'd2 : 2'd1;
                end
                OP_ALLOC_SMALL:
                begin
                    alloc_next = alloc_base + {25'd0, ({1'b0, rg} + 5'd1), 2'd0} * 32'd2;
                    stack_next = stack_base + {25'd0, ({1'b0, rg} + 5'd1), 2'd0} * 32'd2;
                end
                OP_SAVE_NONVOL, OP_SAVE_XMM128:
                begin
                    left_next = 2'd1;
                end
                OP_SAVE_NONVOL_FAR, OP_SAVE_XMM128_FAR:
                begin
                    left_next = 2'd2;
                end
                OP_PUSH_MACHFRAME:
                begin
                    stack_next = stack_base
                        + ((rg != 4'd0) ? MACHFRAME_CODE : MACHFRAME_NOCODE);
                end
                default:
                begin
                end
            endcase
        end

        truncated = 1'b0;
        if (slot.last_slot)
        begin
            truncated = (left_next != 2'd0);
            left_next = 2'd0;
            low_next  = 16'd0;
            pop_next  = 4'd0;
            preg_next = 4'd0;
        end

        save_rec.record_kind  = KIND_SAVE;
        save_rec.reg_id       = s_reg;
        save_rec.frame_offset = s_off;
        save_rec.is_xmm       = s_xmm;
        save_rec.frame_size   = alloc_next;
        save_rec.stack_depth  = stack_next;
        save_rec.truncated    = 1'b0;
        save_rec.last_result  = !slot.last_slot;

        sum_rec.record_kind  = KIND_SUMMARY;
        sum_rec.reg_id       = 5'd0;
        sum_rec.frame_offset = 32'sd0;
        sum_rec.is_xmm       = 1'b0;
        sum_rec.frame_size   = alloc_next;
        sum_rec.stack_depth  = stack_next;
        sum_rec.truncated    = truncated;
        sum_rec.last_result  = 1'b1;

        push_n = slot_fire ? ({1'b0, save} + {1'b0, slot.last_slot}) : 2'd0;
    end

    assign slot_stall   = count_reg > CNT_W'(FIFO_DEPTH - 2);
    assign result_valid = count_reg != '0;
    assign result       = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_reg  <= DEPTH_RESET;
            alloc_reg  <= 32'd0;
            pop_reg    <= 4'd0;
            preg_reg   <= 4'd0;
            left_reg   <= 2'd0;
            low_reg    <= 16'd0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (slot_fire)
            begin
                stack_reg <= stack_next;
                alloc_reg <= alloc_next;
                pop_reg   <= pop_next;
                preg_reg  <= preg_next;
                left_reg  <= left_next;
                low_reg   <= low_next;
            end
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            if (result_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(push_n) - CNT_W'(result_fire);
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_fire)
        begin
            if (save)
            begin
                fifo_reg[wr_ptr_reg] <= save_rec;
                if (slot.last_slot)
                begin
                    fifo_reg[wr_ptr_reg + PTR_W'(1)] <= sum_rec;
                end
            end
            else if (slot.last_slot)
            begin
                fifo_reg[wr_ptr_reg] <= sum_rec;
            end
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for the x64 unwind code decoder (depends on x64uwd_pkg): directed slot table,
// then random records and slots, every result checked against the table or a model.
module tb_top;
    import x64uwd_pkg::*;

    localparam logic [3:0] OP_SET_FRAME   = 4'd3;
    localparam logic [3:0] OP_RESERVED_6  = 4'd6;
    localparam logic [3:0] OP_RESERVED_F  = 4'd15;
    localparam int         IDLE_PCT       = 19;
    localparam int         RANDOM_ITEMS   = 1200;
    localparam int         QUIET_FIRST    = 500;
    localparam int         QUIET_LAST     = 800;
    localparam int         DRAIN_CYCLES   = 10;
    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         REPORT_LIMIT   = 10;

    typedef struct {
        logic [15:0] word;
        logic        sor;
        logic        last;
        bit          typed;
        result_t     exp;
    } stim_row_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    slot_valid;
    logic    slot_stall;
    slot_t   slot;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    bit          quiet = 1'b0;
    int          slots_sent = 0;
    int          record_mismatches = 0;
    int          cycles = 0;
    result_t     expected_records[$];
    stim_row_t   stim_table[$];

    logic [31:0] depth_q;
    logic [31:0] alloc_q;
    logic [3:0]  pend_op;
    logic [3:0]  pend_reg;
    logic [1:0]  operands_left;
    logic [15:0] low_half;

    x64_unwind_code_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .slot_valid   (slot_valid),
        .slot_stall   (slot_stall),
        .slot         (slot),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("x64_unwind_code_decoder test failed");
            $finish;
        end
    end

    function automatic logic [15:0] code_word(logic [3:0] op, logic [3:0] info,
                                              logic [7:0] offs);
        return {info, op, offs};
    endfunction

    function automatic result_t summary_of(logic [31:0] fs, logic [31:0] sd, logic trunc);
        result_t r;
        r = '0;
        r.record_kind = KIND_SUMMARY;
        r.frame_size  = fs;
        r.stack_depth = sd;
        r.truncated   = trunc;
        r.last_result = 1'b1;
        return r;
    endfunction

    function automatic void add_row(logic [15:0] word, logic sor, logic last, bit typed,
                                    result_t exp);
        stim_row_t row;
        row.word  = word;
        row.sor   = sor;
        row.last  = last;
        row.typed = typed;
        row.exp   = exp;
        stim_table.insert(stim_table.size(), row);
    endfunction

    task automatic clear_decoder();
        depth_q       = DEPTH_RESET;
        alloc_q       = '0;
        pend_op       = '0;
        pend_reg      = '0;
        operands_left = '0;
        low_half      = '0;
    endtask

    task automatic decode_slot(input slot_t s, output result_t r0, output result_t r1,
                               output int n);
        logic [3:0]  op;
        logic [3:0]  info;
        logic [31:0] val;
        logic [31:0] amt;
        bit          two;
        bit          save;
        result_t     sv;
        result_t     sm;
        save = 1'b0;
        n    = 0;
        sv   = '0;
        sm   = '0;
        r0   = '0;
        r1   = '0;
        if (s.start_of_record)
            clear_decoder();
        op   = s.slot_word[11:8];
        info = s.slot_word[15:12];
        if (operands_left == 2'd2)
        begin
            low_half      = s.slot_word;
            operands_left = 2'd1;
        end
        else if (operands_left == 2'd1)
        begin
            two = (pend_op == OP_SAVE_NONVOL_FAR) || (pend_op == OP_SAVE_XMM128_FAR) ||
                  (pend_op == OP_ALLOC_LARGE && pend_reg != 4'd0);
            val = two ? {s.slot_word, low_half} : {16'd0, s.slot_word};
            operands_left = 2'd0;
            case (pend_op)
                OP_ALLOC_LARGE:
                begin
                    amt     = two ? val : (val << 3);
                    alloc_q = alloc_q + amt;
                    depth_q = depth_q + amt;
                end
                OP_SAVE_NONVOL:
                begin
                    save            = 1'b1;
                    sv.reg_id       = {1'b0, pend_reg};
                    sv.frame_offset = val << 3;
                end
                OP_SAVE_NONVOL_FAR:
                begin
                    save            = 1'b1;
                    sv.reg_id       = {1'b0, pend_reg};
                    sv.frame_offset = val;
                end
                OP_SAVE_XMM128:
                begin
                    save            = 1'b1;
                    sv.reg_id       = {1'b1, pend_reg};
                    sv.frame_offset = val << 4;
                    sv.is_xmm       = 1'b1;
                end
                OP_SAVE_XMM128_FAR:
                begin
                    save            = 1'b1;
                    sv.reg_id       = {1'b1, pend_reg};
                    sv.frame_offset = val;
                    sv.is_xmm       = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            pend_op  = op;
            pend_reg = info;
            case (op)
                OP_PUSH_NONVOL:
                begin
                    save            = 1'b1;
                    sv.reg_id       = {1'b0, info};
                    sv.frame_offset = 32'd0 - depth_q - PUSH_BYTES;
                    depth_q         = depth_q + PUSH_BYTES;
                end
                OP_ALLOC_LARGE:
                    operands_left = (info != 4'd0) ? 2'd2 : 2'd1;
                OP_ALLOC_SMALL:
                begin
                    amt     = ({28'd0, info} + 32'd1) << 3;
                    alloc_q = alloc_q + amt;
                    depth_q = depth_q + amt;
                end
                OP_SAVE_NONVOL, OP_SAVE_XMM128:
                    operands_left = 2'd1;
                OP_SAVE_NONVOL_FAR, OP_SAVE_XMM128_FAR:
                    operands_left = 2'd2;
                OP_PUSH_MACHFRAME:
                    depth_q = depth_q + ((info != 4'd0) ? MACHFRAME_CODE : MACHFRAME_NOCODE);
                default:
                begin
                end
            endcase
        end
        if (save)
        begin
            sv.record_kind = KIND_SAVE;
            sv.frame_size  = alloc_q;
            sv.stack_depth = depth_q;
            sv.last_result = !s.last_slot;
            r0 = sv;
            n  = 1;
        end
        if (s.last_slot)
        begin
            sm = summary_of(alloc_q, depth_q, operands_left != 2'd0);
            operands_left = '0;
            low_half      = '0;
            pend_op       = '0;
            pend_reg      = '0;
            if (n == 0)
                r0 = sm;
            else
                r1 = sm;
            n++;
        end
    endtask

    task automatic send_slot(input logic [15:0] word, input logic sor, input logic last,
                             input bit typed, input result_t typed_exp);
        slot_t   s;
        result_t r0;
        result_t r1;
        int      n;
        s.slot_word       = word;
        s.start_of_record = sor;
        s.last_slot       = last;
        @(negedge clk);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            slot_valid <= 1'b0;
            @(negedge clk);
        end
        slot_valid <= 1'b1;
        slot       <= s;
        @(posedge clk);
        while (slot_stall)
            @(posedge clk);
        decode_slot(s, r0, r1, n);
        if (typed)
            expected_records.insert(expected_records.size(), typed_exp);
        else
        begin
            if (n > 0)
                expected_records.insert(expected_records.size(), r0);
            if (n > 1)
                expected_records.insert(expected_records.size(), r1);
        end
        slots_sent++;
    endtask

    function automatic logic [15:0] operand_word();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_record();
        logic [15:0] words[$];
        logic [3:0]  op;
        logic [3:0]  info;
        int          n_codes;
        int          n_operands;
        int          cut;
        bit          with_start;
        bit          with_last;
        n_codes = $urandom_range(1, 6);
        for (int k = 0; k < n_codes; k++)
        begin
            info = 4'($urandom);
            if ($urandom_range(3) == 0)
                op = 4'($urandom);
            else
                case ($urandom_range(7))
                    0: op = OP_PUSH_NONVOL;
                    1: op = OP_ALLOC_LARGE;
                    2: op = OP_ALLOC_SMALL;
                    3: op = OP_SAVE_NONVOL;
                    4: op = OP_SAVE_NONVOL_FAR;
                    5: op = OP_SAVE_XMM128;
                    6: op = OP_SAVE_XMM128_FAR;
                    default: op = OP_PUSH_MACHFRAME;
                endcase
            words.insert(words.size(), code_word(op, info, 8'($urandom)));
            case (op)
                OP_ALLOC_LARGE: n_operands = (info != 4'd0) ? 2 : 1;
                OP_SAVE_NONVOL, OP_SAVE_XMM128: n_operands = 1;
                OP_SAVE_NONVOL_FAR, OP_SAVE_XMM128_FAR: n_operands = 2;
                default: n_operands = 0;
            endcase
            repeat (n_operands)
                words.insert(words.size(), operand_word());
        end
        cut = words.size();
        if ($urandom_range(9) == 0)
            cut = $urandom_range(1, words.size());
        with_start = ($urandom_range(19) != 0);
        with_last  = ($urandom_range(19) != 0);
        for (int k = 0; k < cut; k++)
            send_slot(words[k], (k == 0) && with_start, (k == cut - 1) && with_last,
                      1'b0, '0);
    endtask

    always @(negedge clk)
        result_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);

    always @(posedge clk)
    begin : check_results
        result_t exp;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_records.size() == 0)
            begin
                record_mismatches++;
                if (record_mismatches <= REPORT_LIMIT)
                    $display("unexpected result transfer: kind %0b reg %0d off %0d",
                             result.record_kind, result.reg_id, result.frame_offset);
            end
            else
            begin
                exp = expected_records.pop_front();
                if (result.record_kind  !== exp.record_kind  ||
                    result.reg_id       !== exp.reg_id       ||
                    result.frame_offset !== exp.frame_offset ||
                    result.is_xmm       !== exp.is_xmm       ||
                    result.frame_size   !== exp.frame_size   ||
                    result.stack_depth  !== exp.stack_depth  ||
                    result.truncated    !== exp.truncated    ||
                    result.last_result  !== exp.last_result)
                begin
                    record_mismatches++;
                    if (record_mismatches <= REPORT_LIMIT)
                    begin
                        $display("expected: kind %0b reg %0d off %0d xmm %0b fs %h sd %h",
                                 exp.record_kind, exp.reg_id, exp.frame_offset, exp.is_xmm,
                                 exp.frame_size, exp.stack_depth);
                        $display("          trunc %0b last %0b",
                                 exp.truncated, exp.last_result);
                        $display("actual:   kind %0b reg %0d off %0d xmm %0b fs %h sd %h",
                                 result.record_kind, result.reg_id, result.frame_offset,
                                 result.is_xmm, result.frame_size, result.stack_depth);
                        $display("          trunc %0b last %0b",
                                 result.truncated, result.last_result);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        slot_valid   = 1'b0;
        slot         = '0;
        result_stall = 1'b0;
        clear_decoder();

        add_row(code_word(OP_SET_FRAME, 4'd0, 8'h00), 1'b0, 1'b1, 1'b1,
                summary_of(32'd0, 32'd8, 1'b0));
        add_row(code_word(OP_ALLOC_SMALL, 4'd15, 8'hFF), 1'b1, 1'b1, 1'b1,
                summary_of(32'd128, 32'd136, 1'b0));
        add_row(code_word(OP_RESERVED_F, 4'd15, 8'hFF), 1'b1, 1'b1, 1'b1,
                summary_of(32'd0, 32'd8, 1'b0));
        add_row(code_word(OP_PUSH_MACHFRAME, 4'd1, 8'h00), 1'b1, 1'b1, 1'b1,
                summary_of(32'd0, 32'd56, 1'b0));
        add_row(code_word(OP_ALLOC_LARGE, 4'd0, 8'h00), 1'b1, 1'b1, 1'b1,
                summary_of(32'd0, 32'd8, 1'b1));
        add_row(code_word(OP_PUSH_NONVOL, 4'd15, 8'h01), 1'b1, 1'b0, 1'b0, '0);
        add_row(code_word(OP_ALLOC_LARGE, 4'd0, 8'h10), 1'b0, 1'b0, 1'b0, '0);
        add_row(16'hFFFF, 1'b0, 1'b0, 1'b0, '0);
        add_row(code_word(OP_ALLOC_LARGE, 4'd15, 8'h20), 1'b0, 1'b0, 1'b0, '0);
        add_row(16'hFFFF, 1'b0, 1'b0, 1'b0, '0);
        add_row(16'hFFFF, 1'b0, 1'b0, 1'b0, '0);
        add_row(code_word(OP_SAVE_NONVOL, 4'd3, 8'h30), 1'b0, 1'b0, 1'b0, '0);
        add_row(16'hFFFF, 1'b0, 1'b0, 1'b0, '0);
        add_row(code_word(OP_SAVE_NONVOL_FAR, 4'd12, 8'h40), 1'b0, 1'b0, 1'b0, '0);
        add_row(16'h0000, 1'b0, 1'b0, 1'b0, '0);
        add_row(16'h8000, 1'b0, 1'b0, 1'b0, '0);
        add_row(code_word(OP_RESERVED_6, 4'd9, 8'h55), 1'b0, 1'b0, 1'b0, '0);
        add_row(code_word(OP_PUSH_MACHFRAME, 4'd0, 8'h60), 1'b0, 1'b0, 1'b0, '0);
        add_row(code_word(OP_SAVE_XMM128, 4'd15, 8'h70), 1'b0, 1'b0, 1'b0, '0);
        add_row(16'h1234, 1'b0, 1'b1, 1'b0, '0);
        add_row(code_word(OP_SAVE_XMM128_FAR, 4'd7, 8'h80), 1'b1, 1'b0, 1'b0, '0);
        add_row(16'hFFFF, 1'b0, 1'b0, 1'b0, '0);
        add_row(16'hFFFF, 1'b0, 1'b0, 1'b0, '0);
        add_row(code_word(OP_SAVE_NONVOL_FAR, 4'd1, 8'h90), 1'b0, 1'b0, 1'b0, '0);
        add_row(code_word(OP_PUSH_NONVOL, 4'd5, 8'hA0), 1'b1, 1'b1, 1'b0, '0);
        add_row(code_word(OP_ALLOC_SMALL, 4'd3, 8'hB0), 1'b0, 1'b0, 1'b0, '0);
        add_row(code_word(OP_SAVE_XMM128_FAR, 4'd2, 8'hC0), 1'b0, 1'b0, 1'b0, '0);
        add_row(16'hAAAA, 1'b0, 1'b1, 1'b0, '0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_table[i])
            send_slot(stim_table[i].word, stim_table[i].sor, stim_table[i].last,
                      stim_table[i].typed, stim_table[i].exp);

        while (slots_sent < stim_table.size() + RANDOM_ITEMS)
        begin
            quiet = (slots_sent >= QUIET_FIRST) && (slots_sent < QUIET_LAST);
            if ($urandom_range(9) == 0)
                send_slot(16'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'b0, '0);
            else
                send_random_record();
        end
        quiet = 1'b0;

        @(negedge clk);
        slot_valid <= 1'b0;
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (record_mismatches == 0 && expected_records.size() == 0)
            $display("x64_unwind_code_decoder test passed");
        else
            $display("x64_unwind_code_decoder test failed");
        $finish;
    end

endmodule
